FILE: src/sacl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and helpers for the set-associative cache model
// Holds the line record, the controller/datapath command and status groups,
// the register indices and the saturating increment helpers.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int DEF_MAX_SETS = 1024;
    localparam int DEF_MAX_WAYS = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_MODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_MODE   = 3'd4;

    localparam logic MODE_LRU = 1'b0;
    localparam logic MODE_LFU = 1'b1;
    localparam logic MODE_WB  = 1'b0;
    localparam logic MODE_WT  = 1'b1;

    // Masked set value before the modulo: index_bits is at most 15.
    localparam int SETV_W = 15;

    typedef struct packed {
        logic [31:0] tag;
        logic        valid;
        logic        dirty;
        logic [15:0] rank;
    } t_line;

    typedef struct packed {
        logic clr;     // write a zero row at the clear pointer
        logic accept;  // input transfer taken this cycle
        logic quo;     // form the quotient for the set modulo
        logic rd;      // read the set row
        logic upd;     // write the row back and load the result
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic out_busy;
    } t_status;

    function automatic logic [15:0] inc16(input logic [15:0] v);
        inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [31:0] inc32(input logic [31:0] v);
        inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

FILE: src/sacl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ctrl: access sequencer
// Runs the clearing pass after reset, then steps each access through the
// optional set modulo, the row read and the row update.
// ----------------------------------------------------------------------------
module sacl_ctrl #(
    parameter bit DIRECT = 1'b1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output sacl_pkg::t_cmd     o_cmd,
    input  sacl_pkg::t_status  i_status
);
    import sacl_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUO,
        ST_RD,
        ST_UPD
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.clr    = (r_state == ST_CLEAR);
        o_cmd.accept = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.quo    = (r_state == ST_QUO);
        o_cmd.rd     = (r_state == ST_RD);
        o_cmd.upd    = (r_state == ST_UPD) && !i_status.out_busy;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (i_status.clr_done) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_in_valid) n_state = DIRECT ? ST_UPD : ST_QUO;
            end
            ST_QUO: n_state = ST_RD;
            ST_RD: n_state = ST_UPD;
            ST_UPD: if (!i_status.out_busy) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: src/sacl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_dp: cache datapath
// Set row memory, address split, way compare, replacement update, running
// totals, configuration registers and the result register.
// ----------------------------------------------------------------------------
module sacl_dp #(
    parameter int MAX_SETS = sacl_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS = sacl_pkg::DEF_MAX_WAYS,
    parameter bit DIRECT   = 1'b1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sacl_pkg::t_cmd                     i_cmd,
    output sacl_pkg::t_status                  o_status,
    input  logic                               i_func,
    input  logic [31:0]                        i_address,
    input  logic                               i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [199:0]                       o_out_data
);
    import sacl_pkg::*;

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W  = $clog2(MAX_WAYS + 1) + 1;
    localparam logic [63:0] RECIP = ((64'd1 << 32) / MAX_SETS) + 64'd1;
    localparam logic [16:0] SETS17 = 17'(MAX_SETS);

    typedef struct packed {
        logic [15:0]                age;
        t_line [MAX_WAYS-1:0]       line;
    } t_row;

    // Configuration
    logic [3:0] r_off_bits, r_idx_bits, r_ways;
    logic       r_rep_mode, r_wr_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_bits <= 4'd4;
            r_idx_bits <= 4'd6;
            r_ways     <= 4'd4;
            r_rep_mode <= MODE_LRU;
            r_wr_mode  <= MODE_WB;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OFFSET_BITS:  r_off_bits <= i_cfg_data;
                REG_INDEX_BITS:   r_idx_bits <= i_cfg_data;
                REG_WAYS_IN_USE:  r_ways     <= i_cfg_data;
                REG_REPLACE_MODE: r_rep_mode <= i_cfg_data[0];
                REG_WRITE_MODE:   r_wr_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Address split
    logic [31:0]       shifted;
    logic [SETV_W-1:0] in_setv;
    logic [31:0]       in_tag;
    logic [SET_W-1:0]  in_set;

    always_comb begin
        shifted = i_address >> r_off_bits;
        in_setv = shifted[SETV_W-1:0] & SETV_W'((16'd1 << r_idx_bits) - 16'd1);
        in_tag  = i_address >> (6'(r_off_bits) + 6'(r_idx_bits));
        in_set  = (MAX_SETS == 1) ? '0 : SET_W'(in_setv);
    end

    logic              r_func;
    logic [31:0]       r_tag;
    logic [SETV_W-1:0] r_setv;
    logic [SETV_W-1:0] r_quo;
    logic [SET_W-1:0]  r_set;
    logic [63:0]       quo_prod;
    logic [16:0]       rem_raw, rem_fix;

    assign quo_prod = 64'(r_setv) * RECIP;

    always_comb begin
        rem_raw = 17'(r_setv) - 17'(17'(r_quo) * SETS17);
        rem_fix = (rem_raw >= SETS17) ? rem_raw - SETS17 : rem_raw;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_func;
            r_tag  <= in_tag;
            r_setv <= in_setv;
            r_set  <= in_set;
        end
        if (i_cmd.quo) r_quo <= SETV_W'(quo_prod >> 32);
        if (i_cmd.rd)  r_set <= SET_W'(rem_fix);
    end

    // Set row memory and clearing pass
    t_row             r_mem [MAX_SETS];
    t_row             r_row, n_row;
    logic [SET_W-1:0] r_clr_idx;
    logic             rd_en, we;
    logic [SET_W-1:0] rd_addr, wr_addr;
    t_row             wr_data;

    assign rd_en   = i_cmd.rd || (i_cmd.accept && DIRECT);
    assign rd_addr = i_cmd.rd ? SET_W'(rem_fix) : in_set;
    assign we      = i_cmd.clr || i_cmd.upd;
    assign wr_addr = i_cmd.clr ? r_clr_idx : r_set;
    assign wr_data = i_cmd.clr ? '0 : n_row;

    assign o_status.clr_done = i_cmd.clr && (32'(r_clr_idx) == MAX_SETS - 1);
    assign o_status.out_busy = o_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr) begin
            r_clr_idx <= r_clr_idx + SET_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_row <= r_mem[rd_addr];
    end

    // Lookup and replacement
    logic [NW_W-1:0]     nw;
    logic [MAX_WAYS-1:0] in_use;
    logic                hit, alloc, wb;
    logic [WAY_W-1:0]    hway, lru_v, lfu_v, vic, way_out;
    logic [15:0]         best_hi, best_lo, hrank;
    logic [1:0]          added;

    always_comb begin
        if (r_ways == 4'd0) nw = NW_W'(1);
        else if (32'(r_ways) > MAX_WAYS) nw = NW_W'(MAX_WAYS);
        else nw = NW_W'(r_ways);

        for (int w = 0; w < MAX_WAYS; w++) in_use[w] = (NW_W'(w) < nw);

        hit  = 1'b0;
        hway = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (in_use[w] && r_row.line[w].valid && r_row.line[w].tag == r_tag) begin
                hit  = 1'b1;
                hway = WAY_W'(w);
            end
        end
        hrank = r_row.line[hway].rank;

        lru_v   = '0;
        lfu_v   = '0;
        best_hi = r_row.line[0].rank;
        best_lo = r_row.line[0].rank;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (in_use[w] && r_row.line[w].rank > best_hi) begin
                best_hi = r_row.line[w].rank;
                lru_v   = WAY_W'(w);
            end
            if (in_use[w] && r_row.line[w].rank < best_lo) begin
                best_lo = r_row.line[w].rank;
                lfu_v   = WAY_W'(w);
            end
        end
        vic = (r_rep_mode == MODE_LFU) ? lfu_v : lru_v;

        alloc   = !hit && (!r_func || r_wr_mode == MODE_WB);
        wb      = alloc && r_wr_mode == MODE_WB && r_row.line[vic].dirty;
        way_out = hit ? hway : (alloc ? vic : '0);
        if (hit) added = {1'b0, r_func && r_wr_mode == MODE_WT};
        else     added = wb ? 2'd2 : 2'd1;

        n_row = r_row;
        if (hit) begin
            if (r_rep_mode == MODE_LFU) begin
                n_row.line[hway].rank = inc16(hrank);
            end else begin
                for (int w = 0; w < MAX_WAYS; w++) begin
                    if (in_use[w] && r_row.line[w].rank < hrank)
                        n_row.line[w].rank = r_row.line[w].rank + 16'd1;
                end
                n_row.line[hway].rank = '0;
            end
            if (r_func && r_wr_mode == MODE_WB) n_row.line[hway].dirty = 1'b1;
        end else if (alloc) begin
            if (r_rep_mode == MODE_LFU) begin
                n_row.age = r_row.line[vic].rank;
                n_row.line[vic].rank = inc16(r_row.line[vic].rank);
            end else begin
                for (int w = 0; w < MAX_WAYS; w++) begin
                    if (in_use[w]) n_row.line[w].rank = inc16(r_row.line[w].rank);
                end
                n_row.line[vic].rank = '0;
            end
            n_row.line[vic].dirty = r_func && r_wr_mode == MODE_WB;
            n_row.line[vic].tag   = r_tag;
            n_row.line[vic].valid = 1'b1;
        end
    end

    // Running totals
    logic [31:0] r_reads, r_rmiss, r_writes, r_wmiss, r_wbs, r_traffic;
    logic [31:0] n_reads, n_rmiss, n_writes, n_wmiss, n_wbs, n_traffic;

    always_comb begin
        n_reads   = r_func ? r_reads : inc32(r_reads);
        n_writes  = r_func ? inc32(r_writes) : r_writes;
        n_rmiss   = (!hit && !r_func) ? inc32(r_rmiss) : r_rmiss;
        n_wmiss   = (!hit && r_func) ? inc32(r_wmiss) : r_wmiss;
        n_wbs     = wb ? inc32(r_wbs) : r_wbs;
        n_traffic = r_traffic;
        if (added != 2'd0) n_traffic = inc32(n_traffic);
        if (added == 2'd2) n_traffic = inc32(n_traffic);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reads   <= '0;
            r_rmiss   <= '0;
            r_writes  <= '0;
            r_wmiss   <= '0;
            r_wbs     <= '0;
            r_traffic <= '0;
        end else if (i_cmd.upd) begin
            r_reads   <= n_reads;
            r_rmiss   <= n_rmiss;
            r_writes  <= n_writes;
            r_wmiss   <= n_wmiss;
            r_wbs     <= n_wbs;
            r_traffic <= n_traffic;
        end
    end

    // Result register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.upd) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            o_out_data <= {1'b0, n_traffic, n_wbs, n_wmiss, n_writes, n_rmiss, n_reads,
                           added, wb, 3'(way_out), hit};
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: src/set_assoc_cache_lru_lfu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lfu: set-associative cache tag and policy engine
// Looks up each access in its set, updates LRU ranks or LFU counts, picks
// victims, tracks dirty lines and reports the outcome with running totals.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass, one set row a cycle, and
// accepts no access until it is done; configuration writes are taken at any
// time. When MAX_SETS is a power of two (or at least 32768), the transfer
// cycle reads the set row from the single-port row memory, and the update
// step compares the ways in use, writes the updated row back and loads the
// result register; it waits while a held result is not taken. For other
// MAX_SETS values the set index modulo adds a reciprocal multiply and a
// correction before the row read. The row memory read-modify-write sets the
// rate. A result waits in its own register, so a stalled result only delays
// the update of the following access. Configuration is to be written only
// while no access is in flight.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lfu #(
    parameter int MAX_SETS = sacl_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS = sacl_pkg::DEF_MAX_WAYS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Access stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [31:0]                      s_axis_tdata,  // address[31:0]
    input  logic [0:0]                       s_axis_tuser,  // func (0 read, 1 write)
    // Result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // From bit 0: hit, way[2:0], writeback, traffic_added[1:0], reads_total,
    // read_misses_total, writes_total, write_misses_total, writebacks_total,
    // traffic_total (32 bits each), one zero pad bit.
    output logic [199:0]                     m_axis_tdata,
    // Configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sacl_pkg::*;

    // The set modulo reduces to a bit-select when the set count is a power of
    // two, or when it exceeds every value that index_bits can select.
    localparam bit DIRECT = ((MAX_SETS & (MAX_SETS - 1)) == 0) || (MAX_SETS >= 32768);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    sacl_ctrl #(
        .DIRECT (DIRECT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    sacl_dp #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS),
        .DIRECT   (DIRECT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_func      (s_axis_tuser[0]),
        .i_address   (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

FILE: verif/cache_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_access_checker: predicts and checks every cache access outcome
// Watches the access, result and configuration channels. It keeps its own
// copy of the tag, valid, dirty and replacement state of every line. It works
// out the outcome of each accepted access and compares each result field with
// the oldest outcome still outstanding.
// ----------------------------------------------------------------------------
module cache_access_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_acc_valid,
    input  logic         i_acc_ready,
    input  logic [31:0]  i_acc_addr,
    input  logic         i_acc_write,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic [199:0] i_res_data,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [3:0]   i_cfg_data,
    output int           o_fail_count,
    output int           o_pending
);
    import sacl_pkg::*;

    localparam int SETS  = 1024;
    localparam int WAYS  = 8;
    localparam int LINES = SETS * WAYS;

    // Same layout as the result bus, most significant field first.
    typedef struct packed {
        logic [31:0] traffic_total;
        logic [31:0] writebacks_total;
        logic [31:0] write_misses_total;
        logic [31:0] writes_total;
        logic [31:0] read_misses_total;
        logic [31:0] reads_total;
        logic [1:0]  traffic_added;
        logic        writeback;
        logic [2:0]  way;
        logic        hit;
    } t_outcome;

    logic [31:0] line_tag   [LINES];
    logic        line_valid [LINES];
    logic        line_dirty [LINES];
    logic [15:0] line_rank  [LINES];
    logic [15:0] age_of_set [SETS];

    logic [31:0] n_reads, n_read_misses, n_writes, n_write_misses;
    logic [31:0] n_writebacks, n_traffic;
    logic [3:0]  cfg_offset, cfg_index, cfg_ways;
    logic        cfg_lfu, cfg_wt;

    t_outcome outcome_q[$];
    int       n_fail;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
        n_fail++;
    endtask

    // Look the access up in its set and update the line state as the cache does.
    task automatic predict_access(input logic wr, input logic [31:0] addr,
                                  output t_outcome o);
        logic [31:0] mask, tg;
        int          set_no, base, nw, vic, line;
        logic [15:0] r;
        int          best;
        o = '0;
        nw = (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS) ? WAYS : int'(cfg_ways));
        mask = (32'd1 << cfg_index) - 32'd1;
        set_no = int'(((addr >> cfg_offset) & mask) % SETS);
        tg = addr >> (6'(cfg_offset) + 6'(cfg_index));
        base = set_no * WAYS;

        if (wr) n_writes = sat_inc32(n_writes);
        else    n_reads  = sat_inc32(n_reads);

        for (int w = 0; w < nw && !o.hit; w++) begin
            if (line_valid[base+w] && line_tag[base+w] == tg) begin
                o.hit = 1'b1;
                o.way = w[2:0];
            end
        end

        if (o.hit) begin
            line = base + int'(o.way);
            if (cfg_lfu == MODE_LFU) begin
                line_rank[line] = sat_inc16(line_rank[line]);
            end else begin
                r = line_rank[line];
                for (int w = 0; w < nw; w++)
                    if (line_rank[base+w] < r) line_rank[base+w] = line_rank[base+w] + 16'd1;
                line_rank[line] = '0;
            end
            if (wr) begin
                if (cfg_wt == MODE_WT) begin
                    o.traffic_added = 2'd1;
                    n_traffic = sat_inc32(n_traffic);
                end else begin
                    line_dirty[line] = 1'b1;
                end
            end
        end else begin
            if (wr) n_write_misses = sat_inc32(n_write_misses);
            else    n_read_misses  = sat_inc32(n_read_misses);
            o.traffic_added = 2'd1;
            n_traffic = sat_inc32(n_traffic);
            // A write-through write miss leaves the set untouched.
            if (!wr || cfg_wt == MODE_WB) begin
                vic = 0;
                if (cfg_lfu == MODE_LFU) begin
                    best = 32'h10000;
                    for (int w = 0; w < nw; w++)
                        if (int'(line_rank[base+w]) < best) begin
                            best = int'(line_rank[base+w]);
                            vic = w;
                        end
                    age_of_set[set_no] = line_rank[base+vic];
                    line_rank[base+vic] = sat_inc16(age_of_set[set_no]);
                end else begin
                    best = -1;
                    for (int w = 0; w < nw; w++)
                        if (int'(line_rank[base+w]) > best) begin
                            best = int'(line_rank[base+w]);
                            vic = w;
                        end
                    for (int w = 0; w < nw; w++)
                        line_rank[base+w] = sat_inc16(line_rank[base+w]);
                    line_rank[base+vic] = '0;
                end
                line = base + vic;
                o.way = vic[2:0];
                if (cfg_wt == MODE_WB && line_dirty[line]) begin
                    o.writeback = 1'b1;
                    o.traffic_added = 2'd2;
                    n_traffic = sat_inc32(n_traffic);
                    n_writebacks = sat_inc32(n_writebacks);
                end
                line_dirty[line] = wr && cfg_wt == MODE_WB;
                line_tag[line]   = tg;
                line_valid[line] = 1'b1;
            end
        end

        o.reads_total        = n_reads;
        o.read_misses_total  = n_read_misses;
        o.writes_total       = n_writes;
        o.write_misses_total = n_write_misses;
        o.writebacks_total   = n_writebacks;
        o.traffic_total      = n_traffic;
    endtask

    always @(posedge i_clk) begin
        t_outcome want, got;
        if (!i_rst_n) begin
            for (int i = 0; i < LINES; i++) begin
                line_tag[i]   = '0;
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
                line_rank[i]  = '0;
            end
            for (int i = 0; i < SETS; i++) age_of_set[i] = '0;
            n_reads = '0; n_read_misses = '0; n_writes = '0;
            n_write_misses = '0; n_writebacks = '0; n_traffic = '0;
            cfg_offset = 4'd4; cfg_index = 4'd6; cfg_ways = 4'd4;
            cfg_lfu = MODE_LRU; cfg_wt = MODE_WB;
            outcome_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_OFFSET_BITS:  cfg_offset = i_cfg_data;
                    REG_INDEX_BITS:   cfg_index  = i_cfg_data;
                    REG_WAYS_IN_USE:  cfg_ways   = i_cfg_data;
                    REG_REPLACE_MODE: cfg_lfu    = i_cfg_data[0];
                    REG_WRITE_MODE:   cfg_wt     = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                got = t_outcome'(i_res_data[198:0]);
                if (outcome_q.size() == 0) begin
                    report_mismatch("unexpected result", 32'd0, 32'd0);
                end else begin
                    want = outcome_q.pop_front();
                    if (got.hit != want.hit)
                        report_mismatch("hit", got.hit, want.hit);
                    if (got.way != want.way)
                        report_mismatch("way", got.way, want.way);
                    if (got.writeback != want.writeback)
                        report_mismatch("writeback", got.writeback, want.writeback);
                    if (got.traffic_added != want.traffic_added)
                        report_mismatch("traffic_added", got.traffic_added,
                                        want.traffic_added);
                    if (got.reads_total != want.reads_total)
                        report_mismatch("reads_total", got.reads_total, want.reads_total);
                    if (got.read_misses_total != want.read_misses_total)
                        report_mismatch("read_misses_total", got.read_misses_total,
                                        want.read_misses_total);
                    if (got.writes_total != want.writes_total)
                        report_mismatch("writes_total", got.writes_total, want.writes_total);
                    if (got.write_misses_total != want.write_misses_total)
                        report_mismatch("write_misses_total", got.write_misses_total,
                                        want.write_misses_total);
                    if (got.writebacks_total != want.writebacks_total)
                        report_mismatch("writebacks_total", got.writebacks_total,
                                        want.writebacks_total);
                    if (got.traffic_total != want.traffic_total)
                        report_mismatch("traffic_total", got.traffic_total,
                                        want.traffic_total);
                end
            end
            if (i_acc_valid && i_acc_ready) begin
                predict_access(i_acc_write, i_acc_addr, want);
                outcome_q.push_back(want);
            end
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= n_fail;
    end

    initial begin
        n_fail       = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the set-associative cache engine
// Drives accesses through several register settings and idling patterns,
// with a short directed opening, and leaves the result checking to the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import sacl_pkg::*;

    // Roughly 1400 accesses spread over eight settings.
    localparam int PHASES        = 8;
    localparam int ITEMS_PER_PH  = 172;
    localparam int WATCHDOG_IDLE = 40000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid, s_tready;
    logic [31:0]  s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid, m_tready;
    logic [199:0] m_tdata;
    logic         cfg_valid, cfg_ready;
    logic [2:0]   cfg_index;
    logic [3:0]   cfg_data;
    int           fail_count, pending;

    // Idling pattern of the current phase, in percent of cycles.
    int           send_idle_pct;
    int           recv_stall_pct;
    // A long result hold-off, counted down by the receiver process.
    int           hold_left;

    // Current address split, so that generated addresses land on chosen sets.
    logic [3:0]   cur_offset, cur_index;
    logic [31:0]  addr_pool [16];
    int           quiet_cycles;

    // Register settings of the phases.
    logic [3:0] set_ob [PHASES] = '{4'd4, 4'd0, 4'd12, 4'd15, 4'd3, 4'd5, 4'd2, 4'd6};
    logic [3:0] set_ib [PHASES] = '{4'd6, 4'd0, 4'd10, 4'd15, 4'd2, 4'd3, 4'd1, 4'd4};
    logic [3:0] set_nw [PHASES] = '{4'd4, 4'd1, 4'd8, 4'd15, 4'd0, 4'd8, 4'd2, 4'd3};
    logic       set_lfu[PHASES] = '{MODE_LRU, MODE_LRU, MODE_LFU, MODE_LFU,
                                    MODE_LRU, MODE_LFU, MODE_LRU, MODE_LFU};
    logic       set_wt [PHASES] = '{MODE_WB, MODE_WB, MODE_WB, MODE_WT,
                                    MODE_WT, MODE_WB, MODE_WB, MODE_WT};

    set_assoc_cache_lru_lfu dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),   // address[31:0]
        .s_axis_tuser  (s_tuser),   // func (0 read, 1 write)
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),   // hit, way, writeback, traffic_added, totals
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    cache_access_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_acc_valid  (s_tvalid),
        .i_acc_ready  (s_tready),
        .i_acc_addr   (s_tdata),
        .i_acc_write  (s_tuser[0]),
        .i_res_valid  (m_tvalid),
        .i_res_ready  (m_tready),
        .i_res_data   (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The receiver either serves a requested hold-off or stalls at random.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // The watchdog counts cycles in which no transfer happens on any channel.
    // The clearing pass after reset and the long hold-off both fit well inside.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_IDLE) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one access and hold it until the block takes the transfer.
    // Random idle cycles come first, so gaps fall at every point of the flow.
    task automatic send_access(input logic wr, input logic [31:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        s_tuser  <= wr;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_OFFSET_BITS) cur_offset = val;
        if (idx == REG_INDEX_BITS)  cur_index  = val;
    endtask

    // Stop offering and wait until every outstanding result has come back.
    // The extra idle cycles give a margin before any register write.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Mostly reuse of a small working set, so that hits, evictions and dirty
    // write-backs are frequent; some fully random addresses for bit coverage.
    function automatic logic [31:0] pick_address();
        logic [31:0] a, off_mask, set_mask;
        int          roll, slot;
        roll = $urandom_range(0, 99);
        off_mask = (32'd1 << cur_offset) - 32'd1;
        set_mask = (32'd1 << cur_index) - 32'd1;
        slot = $urandom_range(0, 15);
        if (roll < 12) begin
            a = $urandom;
        end else if (roll < 60) begin
            a = addr_pool[slot] ^ ($urandom & off_mask);
        end else begin
            a = (32'($urandom_range(0, 11)) << (6'(cur_offset) + 6'(cur_index)))
              | ((32'($urandom_range(0, 3)) & set_mask) << cur_offset)
              | ($urandom & off_mask);
            addr_pool[slot] = a;
        end
        return a;
    endfunction

    task automatic apply_setting(input logic [3:0] ob, input logic [3:0] ib,
                                 input logic [3:0] nw, input logic lfu, input logic wt);
        write_reg(REG_OFFSET_BITS, ob);
        write_reg(REG_INDEX_BITS, ib);
        write_reg(REG_WAYS_IN_USE, nw);
        write_reg(REG_REPLACE_MODE, {3'b000, lfu});
        write_reg(REG_WRITE_MODE, {3'b000, wt});
        foreach (addr_pool[i]) addr_pool[i] = '0;
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        quiet_cycles = 0;
        cur_offset = 4'd4;
        cur_index = 4'd6;
        foreach (addr_pool[i]) addr_pool[i] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++) begin
            apply_setting(set_ob[ph], set_ib[ph], set_nw[ph], set_lfu[ph], set_wt[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase

            if (ph == 0) begin
                // Directed opening on the reset-like split (set 0, tag step 1 << 10):
                // address extremes, a write hit that dirties a line, then five
                // tags in a four-way set so that the dirty line is evicted and
                // written back, then hits on the survivors.
                send_access(1'b0, 32'h0000_0000);
                send_access(1'b1, 32'h0000_0000);
                send_access(1'b0, 32'hFFFF_FFFF);
                send_access(1'b1, 32'hFFFF_FFFF);
                send_access(1'b0, 32'h0000_000F);
                for (int t = 1; t <= 5; t++) send_access(1'b0, 32'(t) << 10);
                for (int t = 5; t >= 2; t--) send_access(1'b1, 32'(t) << 10);
                send_access(1'b0, 32'h0000_0000);
                send_access(1'b1, 32'h0000_1400);
                send_access(1'b0, 32'h8000_0000);
                send_access(1'b1, 32'h7FFF_FFFF);
                send_access(1'b0, 32'hAAAA_AAAA);
                send_access(1'b1, 32'h5555_5555);
            end
            if (ph == 1) begin
                // Keep results back for a long stretch while accesses keep coming.
                hold_left = 400;
            end

            for (int n = 0; n < ITEMS_PER_PH; n++) begin
                // Once, the sender stops and lets every result come back.
                if (ph == 2 && n == 60) begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
                send_access(1'($urandom_range(0, 1)), pick_address());
            end
            drain_results();
        end

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
